// ----- hw/rtl/tws_pkg.sv -----
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types, widths, reset values and the phase decode for the two-wire
// stepper sequencer.
// ----------------------------------------------------------------------------
package tws_pkg;

	localparam int unsigned DelayWidth    = 32;
	localparam int unsigned PosWidth      = 16;
	localparam int unsigned MoveWidth     = 16;
	localparam int unsigned CfgDataWidth  = 32;
	localparam int unsigned CfgIndexWidth = 1;

	localparam logic [DelayWidth-1:0] DelayReset     = DelayWidth'(1000);
	localparam logic [PosWidth-1:0]   StepsRevReset  = PosWidth'(1600);

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_STEP_DELAY    = 1'b0,
		REG_STEPS_PER_REV = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_MOVE = 1'b0,
		KIND_TICK = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic                coil_a;
		logic                coil_b;
		logic [PosWidth-1:0] position;
		logic                busy_res;
		logic                stepped;
	} result_t;

	// Two-wire Gray phase pattern, returned as {coil_a, coil_b}
	function automatic logic [1:0] gray_for(input logic [1:0] phase);
		logic [1:0] levels;
		case (phase)
			2'd0:    levels = 2'b01;
			2'd1:    levels = 2'b11;
			2'd2:    levels = 2'b10;
			default: levels = 2'b00;
		endcase
		return levels;
	endfunction

endpackage

// ----- hw/rtl/tws_cmd_if.sv -----
// ----------------------------------------------------------------------------
// tws_cmd_if
// Command channel: move commands and time ticks.
// ----------------------------------------------------------------------------
interface tws_cmd_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic signed [tws_pkg::MoveWidth-1:0] move_steps;

	modport source (output valid, output kind, output move_steps, input ready);
	modport sink   (input valid, input kind, input move_steps, output ready);
endinterface

// ----- hw/rtl/tws_res_if.sv -----
// ----------------------------------------------------------------------------
// tws_res_if
// Result channel: wire levels, rotor position and step status per item.
// ----------------------------------------------------------------------------
interface tws_res_if;
	logic                          valid;
	logic                          ready;
	logic                          coil_a;
	logic                          coil_b;
	logic [tws_pkg::PosWidth-1:0]  position;
	logic                          busy_res;
	logic                          stepped;

	modport source (
		output valid, output coil_a, output coil_b, output position,
		output busy_res, output stepped, input ready
	);
	modport sink (
		input valid, input coil_a, input coil_b, input position,
		input busy_res, input stepped, output ready
	);
endinterface

// ----- hw/rtl/tws_step_unit.sv -----
// ----------------------------------------------------------------------------
// tws_step_unit
// Motor state (position, remaining steps, direction, tick count, wires) and
// the update of that state for one item.
// ----------------------------------------------------------------------------
module tws_step_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 fire,
	input  logic                                 kind,
	input  logic signed [tws_pkg::MoveWidth-1:0] move_steps,
	input  logic [tws_pkg::DelayWidth-1:0]       delay_ticks,
	input  logic [tws_pkg::PosWidth-1:0]         steps_per_rev,
	output tws_pkg::result_t                     res
);

	logic [tws_pkg::PosWidth-1:0]   rotor_pos_q;
	logic [tws_pkg::MoveWidth-1:0]  remain_q;
	logic                           forward_q;
	logic [tws_pkg::DelayWidth-1:0] elapsed_q;
	logic [1:0]                     wires_q;

	logic [tws_pkg::PosWidth-1:0]   rotor_pos_d;
	logic [tws_pkg::MoveWidth-1:0]  remain_d;
	logic                           forward_d;
	logic [tws_pkg::DelayWidth-1:0] elapsed_d;
	logic [1:0]                     wires_d;

	logic                           is_move;
	logic                           negative;
	logic [tws_pkg::MoveWidth-1:0]  magnitude;
	logic [tws_pkg::DelayWidth-1:0] elapsed_inc;
	logic                           due;
	logic [tws_pkg::PosWidth-1:0]   rev;
	logic [tws_pkg::PosWidth:0]     pos_plus;
	logic [tws_pkg::PosWidth-1:0]   pos_stepped;

	assign is_move   = (tws_pkg::item_kind_t'(kind) == tws_pkg::KIND_MOVE);
	assign negative  = move_steps[tws_pkg::MoveWidth-1];
	// -32768 negates to 0x8000, which is the right magnitude
	assign magnitude = negative ? tws_pkg::MoveWidth'(-move_steps)
	                            : tws_pkg::MoveWidth'(move_steps);

	// saturate the tick count at all ones
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
	assign due = !is_move && (remain_q != '0) && (elapsed_inc >= delay_ticks);

	assign rev      = (steps_per_rev == '0) ? tws_pkg::PosWidth'(1) : steps_per_rev;
	assign pos_plus = {1'b0, rotor_pos_q} + 1'b1;

	always_comb begin
		if (forward_q) begin
			if (pos_plus >= {1'b0, rev}) begin
				pos_stepped = '0;
			end else begin
				pos_stepped = pos_plus[tws_pkg::PosWidth-1:0];
			end
		end else begin
			// from zero or from beyond a shortened revolution, go to the top
			if (rotor_pos_q == '0 || rotor_pos_q >= rev) begin
				pos_stepped = rev - 1'b1;
			end else begin
				pos_stepped = rotor_pos_q - 1'b1;
			end
		end
	end

	always_comb begin
		rotor_pos_d = rotor_pos_q;
		remain_d    = remain_q;
		forward_d   = forward_q;
		elapsed_d   = elapsed_q;
		wires_d     = wires_q;
		if (is_move) begin
			forward_d = !negative && (move_steps != '0);
			remain_d  = magnitude;
			elapsed_d = '1;
		end else if (remain_q != '0) begin
			elapsed_d = elapsed_inc;
			if (due) begin
				elapsed_d   = '0;
				remain_d    = remain_q - 1'b1;
				rotor_pos_d = pos_stepped;
				wires_d     = tws_pkg::gray_for(pos_stepped[1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotor_pos_q <= '0;
			remain_q    <= '0;
			forward_q   <= 1'b0;
			elapsed_q   <= '0;
			wires_q     <= 2'b00;
		end else if (fire) begin
			rotor_pos_q <= rotor_pos_d;
			remain_q    <= remain_d;
			forward_q   <= forward_d;
			elapsed_q   <= elapsed_d;
			wires_q     <= wires_d;
		end
	end

	assign res.coil_a   = wires_d[1];
	assign res.coil_b   = wires_d[0];
	assign res.position = rotor_pos_d;
	assign res.busy_res = (remain_d != '0);
	assign res.stepped  = due;

`ifndef SYNTH
	a_step_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		fire && due |-> remain_q != '0)
		else $error("step taken with no steps remaining");

	a_pos_in_rev: assert property (@(posedge clk) disable iff (!arst_n)
		fire && due |=> rotor_pos_q < $past(rev))
		else $error("position outside revolution after a step");

	a_wires_follow_pos: assert property (@(posedge clk) disable iff (!arst_n)
		fire && due |=> wires_q == tws_pkg::gray_for(rotor_pos_q[1:0]))
		else $error("wire levels do not match position phase");

	a_move_arms_first_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_move |=> (&elapsed_q) && !$past(due))
		else $error("move did not arm the first step");
`endif

endmodule

// ----- hw/rtl/two_wire_stepper_sequencer.sv -----
// ----------------------------------------------------------------------------
// two_wire_stepper_sequencer
// Counts ticks against a step delay, steps the rotor position within one
// revolution and drives the two-wire Gray phase pattern.
//
//   channel  role    payload
//   cmd      sink    kind, move_steps
//   res      source  coil_a, coil_b, position, busy_res, stepped
//   cfg_*    write   cfg_index selects step delay or steps per revolution
//
// One item per cycle while the result channel is not stalled; the input
// register takes an item at its transfer, and the state update then loads
// the result register, where the result waits until its own transfer.
// The state update is a 32-bit tick increment and compare and a 17-bit wrap.
// Reset clears the motor state and loads delay 1000, 1600 steps per rev.
// A stalled result holds the result register, and the input register fills
// behind it before cmd.ready drops.
// ----------------------------------------------------------------------------
module two_wire_stepper_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tws_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [tws_pkg::CfgDataWidth-1:0]    cfg_data,
	tws_cmd_if.sink                             cmd,
	tws_res_if.source                           res
);

	logic [tws_pkg::DelayWidth-1:0]       delay_ticks_q;
	logic [tws_pkg::PosWidth-1:0]         steps_per_rev_q;

	logic                                 valid_s1;
	logic                                 kind_s1;
	logic signed [tws_pkg::MoveWidth-1:0] move_steps_s1;

	logic                                 out_valid_q;
	tws_pkg::result_t                     out_q;
	tws_pkg::result_t                     next_res;

	logic                                 advance;
	logic                                 fire;

	assign advance   = !out_valid_q || res.ready;
	assign fire      = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q   <= tws_pkg::DelayReset;
			steps_per_rev_q <= tws_pkg::StepsRevReset;
		end else if (cfg_we) begin
			case (tws_pkg::cfg_reg_t'(cfg_index))
				tws_pkg::REG_STEP_DELAY:    delay_ticks_q   <= cfg_data;
				tws_pkg::REG_STEPS_PER_REV: steps_per_rev_q <= cfg_data[tws_pkg::PosWidth-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			kind_s1       <= cmd.kind;
			move_steps_s1 <= cmd.move_steps;
		end
	end

	tws_step_unit u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.kind          (kind_s1),
		.move_steps    (move_steps_s1),
		.delay_ticks   (delay_ticks_q),
		.steps_per_rev (steps_per_rev_q),
		.res           (next_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// hold the result while the sink stalls
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= next_res;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.coil_a   = out_q.coil_a;
	assign res.coil_b   = out_q.coil_b;
	assign res.position = out_q.position;
	assign res.busy_res = out_q.busy_res;
	assign res.stepped  = out_q.stepped;

`ifndef SYNTH
	a_fire_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed item did not reach the result register");

	a_stall_blocks_fire: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res.ready |-> !fire)
		else $error("item processed into a stalled result register");

	a_full_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !res.ready |-> !cmd.ready)
		else $error("transfer accepted with both stages full and stalled");
`endif

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-wire stepper sequencer. Move commands and
// ticks go in through the command channel from a queue; an in-bench motor
// model predicts every result, and the monitor compares each result transfer
// field by field, in order. Step delay and steps per revolution change only
// between phases, once the block has drained.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QuietLimit = 4000;
	localparam int HoldCycles = 300;

	typedef struct {
		tws_pkg::item_kind_t kind;
		logic signed [15:0]  steps;
		int                  gap;
	} cmd_item_t;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              cfg_we;
	logic [tws_pkg::CfgIndexWidth-1:0] cfg_index;
	logic [tws_pkg::CfgDataWidth-1:0]  cfg_data;

	tws_cmd_if cmd_ch ();
	tws_res_if res_ch ();

	two_wire_stepper_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	always #5 clk = ~clk;

	// Bench copy of the registers and the motor state
	logic [tws_pkg::DelayWidth-1:0] delay_cfg  = tws_pkg::DelayReset;
	logic [tws_pkg::PosWidth-1:0]   rev_cfg    = tws_pkg::StepsRevReset;
	logic [15:0]                    rotor_pos  = '0;
	logic [15:0]                    remain_cnt = '0;
	logic                           dir_fwd    = 1'b0;
	logic [31:0]                    elapsed    = '0;
	logic [1:0]                     wires      = '0;

	cmd_item_t         queued_cmds[$];
	tws_pkg::result_t  awaited_results[$];
	cmd_item_t         nxt;
	int                gap_left;
	int                fail_count = 0;
	int                quiet_cycles = 0;
	int                hold_asks = 0;
	int                hold_served = 0;
	int                hold_left;
	int                stall_left;
	bit                ready_idling = 1'b0;

	function automatic tws_pkg::result_t next_motor_result(tws_pkg::item_kind_t kind,
			logic signed [15:0] steps);
		tws_pkg::result_t r;
		logic             stepped_now;
		logic [16:0]      rev;
		stepped_now = 1'b0;
		if (kind == tws_pkg::KIND_MOVE) begin
			dir_fwd    = (steps > 0);
			remain_cnt = steps[15] ? 16'(~steps + 16'd1) : 16'(steps);
			elapsed    = '1;
		end else if (remain_cnt != 0) begin
			if (elapsed != '1)
				elapsed = elapsed + 32'd1;
			if (elapsed >= delay_cfg) begin
				elapsed     = '0;
				remain_cnt  = remain_cnt - 16'd1;
				stepped_now = 1'b1;
				rev = (rev_cfg == 0) ? 17'd1 : {1'b0, rev_cfg};
				if (dir_fwd) begin
					if ({1'b0, rotor_pos} + 17'd1 >= rev)
						rotor_pos = '0;
					else
						rotor_pos = rotor_pos + 16'd1;
				end else begin
					// wrap to the top of the revolution, also from beyond it
					if (rotor_pos == 0 || {1'b0, rotor_pos} >= rev)
						rotor_pos = 16'(rev - 17'd1);
					else
						rotor_pos = rotor_pos - 16'd1;
				end
				wires = {rotor_pos[1] ^ rotor_pos[0], ~rotor_pos[1]};
			end
		end
		r.coil_a   = wires[1];
		r.coil_b   = wires[0];
		r.position = rotor_pos;
		r.busy_res = (remain_cnt != 0);
		r.stepped  = stepped_now;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h, want %0h", what, got, want);
		fail_count++;
	endtask

	// Driver: present queued items, hold while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid      <= 1'b0;
			cmd_ch.kind       <= tws_pkg::KIND_TICK;
			cmd_ch.move_steps <= '0;
			gap_left          <= 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				awaited_results.push_back(next_motor_result(
					tws_pkg::item_kind_t'(cmd_ch.kind), cmd_ch.move_steps));
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (gap_left > 0) begin
					cmd_ch.valid <= 1'b0;
					gap_left     <= gap_left - 1;
				end else if (queued_cmds.size() != 0) begin
					nxt = queued_cmds.pop_front();
					cmd_ch.valid      <= 1'b1;
					cmd_ch.kind       <= nxt.kind;
					cmd_ch.move_steps <= nxt.steps;
					gap_left          <= nxt.gap;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer, then choose the next ready level
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left    <= 0;
			stall_left   <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with none awaited", 32'(res_ch.position), 32'd0);
				end else begin
					tws_pkg::result_t want;
					want = awaited_results.pop_front();
					if (res_ch.coil_a !== want.coil_a)
						report_mismatch("coil_a", 32'(res_ch.coil_a), 32'(want.coil_a));
					if (res_ch.coil_b !== want.coil_b)
						report_mismatch("coil_b", 32'(res_ch.coil_b), 32'(want.coil_b));
					if (res_ch.position !== want.position)
						report_mismatch("position", 32'(res_ch.position),
							32'(want.position));
					if (res_ch.busy_res !== want.busy_res)
						report_mismatch("busy_res", 32'(res_ch.busy_res),
							32'(want.busy_res));
					if (res_ch.stepped !== want.stepped)
						report_mismatch("stepped", 32'(res_ch.stepped), 32'(want.stepped));
				end
			end
			if (hold_asks != hold_served) begin
				hold_served  <= hold_asks;
				hold_left    <= HoldCycles;
				res_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left    <= hold_left - 1;
				res_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left   <= stall_left - 1;
				res_ch.ready <= 1'b0;
			end else if (ready_idling && $urandom_range(0, 4) == 0) begin
				stall_left   <= pick_gap();
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QuietLimit) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic push_cmd(tws_pkg::item_kind_t kind, logic signed [15:0] steps, int gap = 0);
		cmd_item_t c;
		c.kind  = kind;
		c.steps = steps;
		c.gap   = gap;
		queued_cmds.push_back(c);
	endtask

	task automatic write_reg(tws_pkg::cfg_reg_t idx, logic [31:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == tws_pkg::REG_STEP_DELAY)
			delay_cfg = data;
		else
			rev_cfg = data[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Checked on the falling edge, once every update of the cycle has settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (queued_cmds.size() != 0 || cmd_ch.valid || awaited_results.size() != 0);
	endtask

	task automatic run_random_phase(logic [31:0] delay, logic [15:0] spr, int n,
			bit gaps_on, bit stalls_on, bit long_hold);
		logic signed [15:0] steps;
		int                 r;
		write_reg(tws_pkg::REG_STEP_DELAY, delay);
		write_reg(tws_pkg::REG_STEPS_PER_REV, {16'd0, spr});
		@(negedge clk);
		ready_idling = stalls_on;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 15) begin
				r = $urandom_range(0, 9);
				if (r < 7) begin
					steps = 16'($urandom_range(1, 8));
					if ($urandom_range(0, 1))
						steps = -steps;
				end else if (r == 7) begin
					steps = '0;
				end else begin
					steps = 16'($urandom());
				end
				push_cmd(tws_pkg::KIND_MOVE, steps, gaps_on ? pick_gap() : 0);
			end else begin
				// payload is ignored on a tick; keep it random
				push_cmd(tws_pkg::KIND_TICK, 16'($urandom()), gaps_on ? pick_gap() : 0);
			end
		end
		if (long_hold)
			hold_asks = hold_asks + 1;
		wait_drained();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = tws_pkg::REG_STEP_DELAY;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: idle tick, first step due at once, zero move
		push_cmd(tws_pkg::KIND_TICK, 16'sd5);
		push_cmd(tws_pkg::KIND_MOVE, 16'sd3);
		push_cmd(tws_pkg::KIND_TICK, '0);
		push_cmd(tws_pkg::KIND_TICK, '0);
		push_cmd(tws_pkg::KIND_MOVE, 16'sd0);
		wait_drained();

		// Extreme move counts, reverse wrap, move while busy
		write_reg(tws_pkg::REG_STEP_DELAY, 32'd2);
		write_reg(tws_pkg::REG_STEPS_PER_REV, 32'd5);
		@(negedge clk);
		push_cmd(tws_pkg::KIND_MOVE, -16'sd32768);
		repeat (3) push_cmd(tws_pkg::KIND_TICK, '1);
		push_cmd(tws_pkg::KIND_MOVE, 16'sd32767);
		repeat (2) push_cmd(tws_pkg::KIND_TICK, '0);
		push_cmd(tws_pkg::KIND_MOVE, -16'sd1);
		repeat (2) push_cmd(tws_pkg::KIND_TICK, '0);
		wait_drained();

		// Zero delay and zero steps per revolution
		write_reg(tws_pkg::REG_STEP_DELAY, 32'd0);
		write_reg(tws_pkg::REG_STEPS_PER_REV, 32'd0);
		@(negedge clk);
		push_cmd(tws_pkg::KIND_MOVE, 16'sd2);
		repeat (2) push_cmd(tws_pkg::KIND_TICK, '0);
		wait_drained();

		// Full revolution, then positions left beyond a lowered revolution
		write_reg(tws_pkg::REG_STEP_DELAY, 32'd1);
		write_reg(tws_pkg::REG_STEPS_PER_REV, 32'd65535);
		@(negedge clk);
		push_cmd(tws_pkg::KIND_MOVE, -16'sd1);
		push_cmd(tws_pkg::KIND_TICK, '0);
		wait_drained();
		write_reg(tws_pkg::REG_STEPS_PER_REV, 32'd4);
		@(negedge clk);
		push_cmd(tws_pkg::KIND_MOVE, 16'sd1);
		push_cmd(tws_pkg::KIND_TICK, '0);
		wait_drained();
		write_reg(tws_pkg::REG_STEPS_PER_REV, 32'd65535);
		@(negedge clk);
		push_cmd(tws_pkg::KIND_MOVE, -16'sd1);
		push_cmd(tws_pkg::KIND_TICK, '0);
		wait_drained();
		write_reg(tws_pkg::REG_STEPS_PER_REV, 32'd10);
		@(negedge clk);
		push_cmd(tws_pkg::KIND_MOVE, -16'sd1);
		push_cmd(tws_pkg::KIND_TICK, '0);
		wait_drained();

		// Longest delay: only the first step comes
		write_reg(tws_pkg::REG_STEP_DELAY, 32'hFFFF_FFFF);
		@(negedge clk);
		push_cmd(tws_pkg::KIND_MOVE, 16'sd3);
		repeat (2) push_cmd(tws_pkg::KIND_TICK, '0);
		wait_drained();

		run_random_phase(32'd1, 16'd4, 50, 1'b1, 1'b1, 1'b0);
		run_random_phase(32'd2, 16'd7, 50, 1'b0, 1'b0, 1'b0);
		// Back-to-back items against a long receiver hold-off
		run_random_phase(32'd1, 16'd6, 60, 1'b0, 1'b1, 1'b1);
		run_random_phase(32'd3, 16'd1600, 50, 1'b1, 1'b0, 1'b0);
		run_random_phase(32'd0, 16'd1, 40, 1'b0, 1'b1, 1'b0);
		run_random_phase(32'd1, 16'd65535, 50, 1'b1, 1'b1, 1'b0);
		run_random_phase(32'd5, 16'd0, 40, 1'b1, 1'b1, 1'b0);
		run_random_phase($urandom_range(1, 3), 16'($urandom_range(1, 12)), 60,
			1'b1, 1'b1, 1'b0);

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
